// ----- src/tun_pkg.sv -----
// Package for the triangle unit normal block: request and result types and constants.
// Used by the top level and the checker; depends on nothing else.
package tun_pkg;

	localparam int unsigned COORD_WIDTH_DEF = 16;
	localparam int unsigned FRAC_BITS_DEF   = 15;
	localparam int unsigned MINMAG_W        = 36;
	localparam int unsigned OUT_W           = 16;
	localparam int unsigned OUT_MAX         = 32767;

	typedef struct packed {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic signed [15:0] bx;
		logic signed [15:0] by_coord;
		logic signed [15:0] bz;
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic signed [15:0] cz;
		logic               last_in;
	} tri_req_t;

	typedef struct packed {
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic               degenerate;
		logic               last_out;
	} norm_res_t;

endpackage

// ----- src/tun_sqrt_cell.sv -----
// One cell of the square root chain: settles one root bit per cycle.
// Depends on nothing; instantiated in a row by the top level.
module tun_sqrt_cell #(
	parameter int unsigned RW     = 36,
	parameter int unsigned SIDE_W = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_i,
	input  logic [2*RW-1:0]     rad_i,
	input  logic [RW+1:0]       rem_i,
	input  logic [RW-1:0]       root_i,
	input  logic [SIDE_W-1:0]   side_i,
	output logic                valid_o,
	output logic [2*RW-1:0]     rad_o,
	output logic [RW+1:0]       rem_o,
	output logic [RW-1:0]       root_o,
	output logic [SIDE_W-1:0]   side_o
);

	logic [RW+1:0] rem_sh;
	logic [RW+1:0] trial;
	logic          fits;

	// The partial remainder never exceeds twice the partial root, so its top bits are zero.
	always_comb begin
		rem_sh = {rem_i[RW-1:0], rad_i[2*RW-1 -: 2]};
		trial  = {root_i, 2'b01};
		fits   = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		rad_o  <= {rad_i[2*RW-3:0], 2'b00};
		rem_o  <= fits ? rem_sh - trial : rem_sh;
		root_o <= {root_i[RW-2:0], fits};
		side_o <= side_i;
	end

endmodule

// ----- src/tun_div_cell.sv -----
// One cell of the division chain: one quotient bit per cycle for all three components.
// Depends on nothing; instantiated in a row by the top level.
module tun_div_cell #(
	parameter int unsigned RW     = 36,
	parameter int unsigned QW     = 16,
	parameter int unsigned SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_i,
	input  logic [RW-1:0]     div_i,
	input  logic [RW:0]       rem_i [3],
	input  logic [QW-1:0]     quo_i [3],
	input  logic [SIDE_W-1:0] side_i,
	output logic              valid_o,
	output logic [RW-1:0]     div_o,
	output logic [RW:0]       rem_o [3],
	output logic [QW-1:0]     quo_o [3],
	output logic [SIDE_W-1:0] side_o
);

	logic [2:0]    ge;
	logic [RW:0]   diff [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ge[k]   = rem_i[k] >= {1'b0, div_i};
			diff[k] = ge[k] ? rem_i[k] - {1'b0, div_i} : rem_i[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else begin
			valid_o <= valid_i;
		end
	end

	// After the subtraction the remainder is below the divisor, so doubling it fits.
	always_ff @(posedge clk) begin
		div_o  <= div_i;
		side_o <= side_i;
		for (int k = 0; k < 3; k++) begin
			rem_o[k] <= {diff[k][RW-1:0], 1'b0};
			quo_o[k] <= {quo_i[k][QW-2:0], ge[k]};
		end
	end

endmodule

// ----- src/triangle_unit_normal_top.sv -----
// Triangle unit normal: cross product, square root chain and division chain.
// Depends on tun_pkg, tun_sqrt_cell and tun_div_cell.
//
// A request is taken on every clock edge at which start is high; busy stays low, since
// the pipeline takes a new triangle in every cycle. Each request gives exactly one result,
// shown on normal for one cycle with done high; the receiver cannot stall it.
// From request to result a triangle passes the edge, product and sum-of-squares stages,
// one cell per root bit, where RW = 2*COORD_WIDTH + 4 is the width of the root, one cell
// per quotient bit and an output register. Throughput is one triangle per cycle.
// The threshold min_magnitude is written on the cfg channel, which is always ready; it
// should be changed only while no triangle is in flight.
// Reset clears the threshold and every valid bit in the pipeline; no result appears until
// a request has gone all the way through.
module triangle_unit_normal_top #(
	parameter int unsigned COORD_WIDTH      = tun_pkg::COORD_WIDTH_DEF,
	parameter int unsigned NORMAL_FRAC_BITS = tun_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  tun_pkg::tri_req_t               vertices,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tun_pkg::MINMAG_W-1:0]    cfg_data,
	output logic                            done,
	output tun_pkg::norm_res_t              normal
);
	import tun_pkg::*;

	localparam int unsigned CW   = COORD_WIDTH;
	localparam int unsigned F    = NORMAL_FRAC_BITS;
	localparam int unsigned EW   = CW + 1;
	localparam int unsigned PW   = 2 * EW;
	localparam int unsigned NW   = PW + 1;
	localparam int unsigned UW   = NW;
	localparam int unsigned LW   = UW / 2;
	localparam int unsigned HW   = UW - LW;
	localparam int unsigned RW   = UW + 1;
	localparam int unsigned SW   = 2 * RW;
	localparam int unsigned QW   = F + 1;
	localparam int unsigned CMPW = (RW > MINMAG_W) ? RW : MINMAG_W;
	localparam int unsigned LIM  = (F >= 15) ? OUT_MAX : ((1 << F) - 1);
	localparam int unsigned SQ_SIDE  = 3 * UW + 4;
	localparam int unsigned DIV_SIDE = 4;

	logic [MINMAG_W-1:0] min_mag_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_mag_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			min_mag_q <= cfg_data;
		end
	end

	// Front stages: edges, products, cross product, square partials and sums.
	logic              v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic              last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;
	logic signed [EW-1:0] e1_s1 [3];
	logic signed [EW-1:0] e2_s1 [3];
	logic signed [PW-1:0] p_s2 [6];
	logic [UW-1:0]     u_s3 [3];
	logic [2:0]        neg_s3, neg_s4, neg_s5, neg_s6;
	logic [UW-1:0]     u_s4 [3], u_s5 [3], u_s6 [3];
	logic [2*HW-1:0]   hh_s4 [3];
	logic [HW+LW-1:0]  hl_s4 [3];
	logic [2*LW-1:0]   ll_s4 [3];
	logic [SW-1:0]     sq_s5 [3];
	logic [SW-1:0]     sum_s6;

	logic signed [CW-1:0] va [3], vb [3], vc [3];
	logic signed [NW-1:0] n_c [3];

	always_comb begin
		va[0] = vertices.ax[CW-1:0];
		va[1] = vertices.ay[CW-1:0];
		va[2] = vertices.az[CW-1:0];
		vb[0] = vertices.bx[CW-1:0];
		vb[1] = vertices.by_coord[CW-1:0];
		vb[2] = vertices.bz[CW-1:0];
		vc[0] = vertices.cx[CW-1:0];
		vc[1] = vertices.cy[CW-1:0];
		vc[2] = vertices.cz[CW-1:0];
		n_c[0] = NW'(p_s2[0]) - NW'(p_s2[1]);
		n_c[1] = NW'(p_s2[2]) - NW'(p_s2[3]);
		n_c[2] = NW'(p_s2[4]) - NW'(p_s2[5]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= vertices.last_in;
		last_s2 <= last_s1;
		last_s3 <= last_s2;
		last_s4 <= last_s3;
		last_s5 <= last_s4;
		last_s6 <= last_s5;
		for (int k = 0; k < 3; k++) begin
			e1_s1[k] <= EW'(vb[k]) - EW'(va[k]);
			e2_s1[k] <= EW'(vc[k]) - EW'(va[k]);
		end
		p_s2[0] <= e1_s1[1] * e2_s1[2];
		p_s2[1] <= e1_s1[2] * e2_s1[1];
		p_s2[2] <= e1_s1[2] * e2_s1[0];
		p_s2[3] <= e1_s1[0] * e2_s1[2];
		p_s2[4] <= e1_s1[0] * e2_s1[1];
		p_s2[5] <= e1_s1[1] * e2_s1[0];
		for (int k = 0; k < 3; k++) begin
			neg_s3[k] <= n_c[k][NW-1];
			u_s3[k]   <= n_c[k][NW-1] ? UW'(-n_c[k]) : UW'(n_c[k]);
			// Each square is split into high and low halves to keep the multipliers narrow.
			hh_s4[k]  <= u_s3[k][UW-1:LW] * u_s3[k][UW-1:LW];
			hl_s4[k]  <= u_s3[k][UW-1:LW] * u_s3[k][LW-1:0];
			ll_s4[k]  <= u_s3[k][LW-1:0] * u_s3[k][LW-1:0];
			sq_s5[k]  <= (SW'(hh_s4[k]) << (2 * LW)) + (SW'(hl_s4[k]) << (LW + 1))
				+ SW'(ll_s4[k]);
			u_s4[k]   <= u_s3[k];
			u_s5[k]   <= u_s4[k];
			u_s6[k]   <= u_s5[k];
		end
		neg_s4 <= neg_s3;
		neg_s5 <= neg_s4;
		neg_s6 <= neg_s5;
		sum_s6 <= sq_s5[0] + sq_s5[1] + sq_s5[2];
	end

	// Square root chain, one cell per root bit.
	logic              sq_v    [RW+1];
	logic [SW-1:0]     sq_rad  [RW+1];
	logic [RW+1:0]     sq_rem  [RW+1];
	logic [RW-1:0]     sq_root [RW+1];
	logic [SQ_SIDE-1:0] sq_side [RW+1];

	assign sq_v[0]    = v_s6;
	assign sq_rad[0]  = sum_s6;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = {u_s6[0], u_s6[1], u_s6[2], neg_s6, last_s6};

	for (genvar i = 0; i < RW; i++) begin : g_sqrt
		tun_sqrt_cell #(
			.RW     (RW),
			.SIDE_W (SQ_SIDE)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (sq_v[i]),
			.rad_i   (sq_rad[i]),
			.rem_i   (sq_rem[i]),
			.root_i  (sq_root[i]),
			.side_i  (sq_side[i]),
			.valid_o (sq_v[i+1]),
			.rad_o   (sq_rad[i+1]),
			.rem_o   (sq_rem[i+1]),
			.root_o  (sq_root[i+1]),
			.side_o  (sq_side[i+1])
		);
	end

	// Division chain, one cell per quotient bit; each component starts at |n|, never above M.
	logic              dv_v    [QW+1];
	logic [RW-1:0]     dv_div  [QW+1];
	logic [RW:0]       dv_rem  [QW+1][3];
	logic [QW-1:0]     dv_quo  [QW+1][3];
	logic [DIV_SIDE-1:0] dv_side [QW+1];

	assign dv_v[0]    = sq_v[RW];
	assign dv_div[0]  = sq_root[RW];
	assign dv_side[0] = sq_side[RW][3:0];
	assign dv_rem[0][0] = (RW + 1)'(sq_side[RW][3*UW+3 -: UW]);
	assign dv_rem[0][1] = (RW + 1)'(sq_side[RW][2*UW+3 -: UW]);
	assign dv_rem[0][2] = (RW + 1)'(sq_side[RW][UW+3 -: UW]);
	assign dv_quo[0][0] = '0;
	assign dv_quo[0][1] = '0;
	assign dv_quo[0][2] = '0;

	for (genvar i = 0; i < QW; i++) begin : g_div
		tun_div_cell #(
			.RW     (RW),
			.QW     (QW),
			.SIDE_W (DIV_SIDE)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (dv_v[i]),
			.div_i   (dv_div[i]),
			.rem_i   (dv_rem[i]),
			.quo_i   (dv_quo[i]),
			.side_i  (dv_side[i]),
			.valid_o (dv_v[i+1]),
			.div_o   (dv_div[i+1]),
			.rem_o   (dv_rem[i+1]),
			.quo_o   (dv_quo[i+1]),
			.side_o  (dv_side[i+1])
		);
	end

	// Rounding, saturation, sign and the degenerate test.
	logic [QW:0]       q_rnd [3];
	logic [QW:0]       q_sat [3];
	logic [OUT_W-1:0]  q_out [3];
	logic              degen_c;
	logic [2:0]        neg_c;

	always_comb begin
		neg_c   = dv_side[QW][3:1];
		degen_c = CMPW'(dv_div[QW]) <= CMPW'(min_mag_q);
		for (int k = 0; k < 3; k++) begin
			// The final remainder has been doubled, so this compare rounds halves up.
			q_rnd[k] = (QW + 1)'(dv_quo[QW][k])
				+ (QW + 1)'(dv_rem[QW][k] >= {1'b0, dv_div[QW]});
			q_sat[k] = (q_rnd[k] > (QW + 1)'(LIM)) ? (QW + 1)'(LIM) : q_rnd[k];
			q_out[k] = neg_c[k] ? OUT_W'(-OUT_W'(q_sat[k])) : OUT_W'(q_sat[k]);
			if (degen_c) begin
				q_out[k] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_v[QW];
		end
	end

	always_ff @(posedge clk) begin
		normal.norm_x     <= q_out[0];
		normal.norm_y     <= q_out[1];
		normal.norm_z     <= q_out[2];
		normal.degenerate <= degen_c;
		normal.last_out   <= dv_side[QW][0];
	end

endmodule

// ----- src/tun_checker.sv -----
// Port-level checker for the triangle unit normal block, bound to the top level.
// Depends on tun_pkg and triangle_unit_normal_top.
module tun_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input tun_pkg::norm_res_t normal
);
	import tun_pkg::*;

	// A degenerate triangle always gives a zero normal.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && normal.degenerate |->
			normal.norm_x == '0 && normal.norm_y == '0 && normal.norm_z == '0)
		else $error("degenerate result with a non-zero normal");

	// A unit vector cannot have all three components zero.
	a_unit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !normal.degenerate |->
			normal.norm_x != '0 || normal.norm_y != '0 || normal.norm_z != '0)
		else $error("non-degenerate result with a zero normal");

	// Saturation is symmetric, so the most negative code never appears.
	a_no_min_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> normal.norm_x != 16'sh8000 && normal.norm_y != 16'sh8000
			&& normal.norm_z != 16'sh8000)
		else $error("normal component outside the saturated range");

	// No result may come out in the cycle after reset has been released.
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !done)
		else $error("result strobe directly after reset");

	// Every request is taken as it arrives.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("request refused");

endmodule

bind triangle_unit_normal_top tun_checker u_tun_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.normal (normal)
);
